// ===== rtl/core/tilt_pkg.sv =====
// ---------------------------------------------------------------------------
// tilt_pkg
// Shared types, widths and the arctangent table of the tilt angle pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tilt_pkg;

    // sample and result widths
    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_W    = 16;

    // cordic datapath: 19-bit mirrored operand, 24 fraction bits below it
    localparam int SCALE_SH   = 24;
    localparam int COORD_W    = SCALE_SH + 19;
    // angle accumulator in units of 2^-16 degree
    localparam int ACC_W      = 27;
    localparam int TAB_W      = 22;
    localparam int TAB_LEN    = 24;
    localparam int IDX_W      = 5;

    // rounding from 2^-16 degree down to 2^-7 degree
    localparam int FRAC_SH    = 9;
    localparam int RND_W      = ACC_W - FRAC_SH;

    localparam logic signed [ACC_W-1:0] DEG180    = ACC_W'(180 * 65536);
    localparam logic signed [ACC_W-1:0] DEG360    = ACC_W'(360 * 65536);
    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << (FRAC_SH - 1));
    localparam logic [RND_W-1:0]        ANG_MAX_R = RND_W'(46080);
    localparam logic [ANGLE_W-1:0]      ANG_MAX   = ANGLE_W'(46080);
    localparam logic [ANGLE_W-1:0]      ANG_HALF  = ANGLE_W'(23040);

    // offset added after the rotation, chosen by the half plane
    typedef enum logic [1:0] {
        OFF_0   = 2'd0,
        OFF_180 = 2'd1,
        OFF_360 = 2'd2
    } offset_t;

    // one angle in flight
    typedef struct packed {
        logic                       zero_num;   // numerator was zero
        logic                       neg_den;    // denominator was negative
        offset_t                    off_sel;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [ACC_W-1:0]    z;
    } lane_t;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [TAB_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = TAB_W'(2949120);
            5'd1:    v = TAB_W'(1740967);
            5'd2:    v = TAB_W'(919879);
            5'd3:    v = TAB_W'(466945);
            5'd4:    v = TAB_W'(234379);
            5'd5:    v = TAB_W'(117304);
            5'd6:    v = TAB_W'(58666);
            5'd7:    v = TAB_W'(29335);
            5'd8:    v = TAB_W'(14668);
            5'd9:    v = TAB_W'(7334);
            5'd10:   v = TAB_W'(3667);
            5'd11:   v = TAB_W'(1833);
            5'd12:   v = TAB_W'(917);
            5'd13:   v = TAB_W'(458);
            5'd14:   v = TAB_W'(229);
            5'd15:   v = TAB_W'(115);
            5'd16:   v = TAB_W'(57);
            5'd17:   v = TAB_W'(29);
            5'd18:   v = TAB_W'(14);
            5'd19:   v = TAB_W'(7);
            5'd20:   v = TAB_W'(4);
            5'd21:   v = TAB_W'(2);
            5'd22:   v = TAB_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tilt_prep.sv =====
// ---------------------------------------------------------------------------
// tilt_prep
// Entry stage: folds each vector into the right half plane and scales it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_prep (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [tilt_pkg::SAMPLE_W-1:0] accel_x,
    input  wire logic signed [tilt_pkg::SAMPLE_W-1:0] accel_y,
    input  wire logic signed [tilt_pkg::SAMPLE_W-1:0] accel_z,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output tilt_pkg::lane_t                           out_lane_a,
    output tilt_pkg::lane_t                           out_lane_b
);
    import tilt_pkg::*;

    logic  valid_reg;
    lane_t lane_a_reg, lane_a_next;
    lane_t lane_b_reg, lane_b_next;

    // fold one (numerator, denominator) pair
    function automatic lane_t fold(input logic signed [SAMPLE_W-1:0] n,
                                   input logic signed [SAMPLE_W-1:0] d);
        lane_t             l;
        logic signed [18:0] ne;
        logic signed [18:0] de;
        logic signed [18:0] xs;
        logic signed [18:0] ys;
        ne = 19'(n);
        de = 19'(d);
        l.zero_num = (n == '0);
        l.neg_den  = d[SAMPLE_W-1];
        if (d[SAMPLE_W-1]) begin
            xs        = -de;
            ys        = -ne;
            l.off_sel = (!n[SAMPLE_W-1] && (n != '0)) ? OFF_360 : OFF_0;
        end else begin
            xs        = de;
            ys        = ne;
            l.off_sel = OFF_180;
        end
        l.x = {xs, {SCALE_SH{1'b0}}};
        l.y = {ys, {SCALE_SH{1'b0}}};
        l.z = '0;
        return l;
    endfunction

    // y over z, then z over x
    always_comb begin
        lane_a_next = fold(accel_y, accel_z);
        lane_b_next = fold(accel_z, accel_x);
    end

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_lane_a = lane_a_reg;
    assign out_lane_b = lane_b_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tilt_cordic_stage.sv =====
// ---------------------------------------------------------------------------
// tilt_cordic_stage
// One registered vectoring CORDIC iteration for both angles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tilt_pkg::lane_t in_lane_a,
    input  wire tilt_pkg::lane_t in_lane_b,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tilt_pkg::lane_t      out_lane_a,
    output tilt_pkg::lane_t      out_lane_b
);
    import tilt_pkg::*;

    localparam logic [IDX_W-1:0] STEP_IDX = IDX_W'(STEP);

    logic  valid_reg;
    lane_t lane_a_reg, lane_a_next;
    lane_t lane_b_reg, lane_b_next;

    // rotate toward the x axis by atan(2^-STEP)
    function automatic lane_t rotate(input lane_t l);
        lane_t                    r;
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [ACC_W-1:0]   a;
        r  = l;
        xs = l.x >>> STEP;
        ys = l.y >>> STEP;
        a  = signed'({{(ACC_W-TAB_W){1'b0}}, atan_lut(STEP_IDX)});
        if (!l.y[COORD_W-1]) begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + a;
        end else begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - a;
        end
        return r;
    endfunction

    always_comb begin
        lane_a_next = rotate(in_lane_a);
        lane_b_next = rotate(in_lane_b);
    end

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_lane_a = lane_a_reg;
    assign out_lane_b = lane_b_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tilt_post.sv =====
// ---------------------------------------------------------------------------
// tilt_post
// Exit stage: adds the half plane offset, rounds to 1/128 degree, clamps,
// and holds the result word for the output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_post (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tilt_pkg::lane_t               in_lane_a,
    input  wire tilt_pkg::lane_t               in_lane_b,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tilt_pkg::ANGLE_W-1:0]       tilt_about_x,
    output logic [tilt_pkg::ANGLE_W-1:0]       tilt_about_y
);
    import tilt_pkg::*;

    logic                valid_reg;
    logic [ANGLE_W-1:0]  ang_a_reg, ang_a_next;
    logic [ANGLE_W-1:0]  ang_b_reg, ang_b_next;

    // final angle of one lane
    function automatic logic [ANGLE_W-1:0] finish(input lane_t l);
        logic signed [ACC_W-1:0] off;
        logic signed [ACC_W-1:0] t;
        logic [RND_W-1:0]        r;
        logic [ANGLE_W-1:0]      v;
        case (l.off_sel)
            OFF_180: off = DEG180;
            OFF_360: off = DEG360;
            default: off = '0;
        endcase
        t = l.z + off;
        if (t[ACC_W-1]) begin
            t = '0;
        end
        t = t + ROUND_ADD;
        r = t[ACC_W-1:FRAC_SH];
        if (r > ANG_MAX_R) begin
            r = ANG_MAX_R;
        end
        if (l.zero_num) begin
            v = l.neg_den ? ANG_MAX : ANG_HALF;
        end else begin
            v = r[ANGLE_W-1:0];
        end
        return v;
    endfunction

    always_comb begin
        ang_a_next = finish(in_lane_a);
        ang_b_next = finish(in_lane_b);
    end

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ang_a_reg <= ang_a_next;
            ang_b_reg <= ang_b_next;
        end
    end

    assign out_valid    = valid_reg;
    assign tilt_about_x = ang_a_reg;
    assign tilt_about_y = ang_b_reg;

endmodule

`default_nettype wire

// ===== rtl/core/accel_tilt_angles_unit.sv =====
// ---------------------------------------------------------------------------
// accel_tilt_angles_unit
// Two tilt angles per accelerometer sample by pipelined vectoring CORDIC.
// ---------------------------------------------------------------------------
// Input channel s_*: one word per sample holds the three signed 16-bit axes.
// Output channel m_*: one word per sample holds atan2(y,z)+180 deg and
// atan2(z,x)+180 deg, unsigned, in units of 1/128 degree (0..46080).
// The pipeline has one fold stage, one registered stage per CORDIC
// iteration (CORDIC_STEPS, capped at 24), and one rounding stage that
// also serves as the output register. Both angles run in parallel lanes.
// Throughput is one word per cycle while m_tready is high.
// Every stage carries its own valid bit and takes a new word when it is
// empty or its successor moves, so bubbles are squeezed out under a stall.
// When m_tready is low, words back up stage by stage; s_tready falls only
// once every stage holds a word. Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline; no state survives
// between samples.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_angles_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // tilt_about_x, tilt_about_y
);
    import tilt_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    logic [STEPS:0] stg_valid;
    logic [STEPS:0] stg_ready;
    lane_t          lane_a [STEPS+1];
    lane_t          lane_b [STEPS+1];
    logic [ANGLE_W-1:0] tilt_about_x;
    logic [ANGLE_W-1:0] tilt_about_y;

    // fold and scale
    tilt_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .accel_x    (signed'(s_tdata[15:0])),
        .accel_y    (signed'(s_tdata[31:16])),
        .accel_z    (signed'(s_tdata[47:32])),
        .out_valid  (stg_valid[0]),
        .out_ready  (stg_ready[0]),
        .out_lane_a (lane_a[0]),
        .out_lane_b (lane_b[0])
    );

    // cordic iterations
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        tilt_cordic_stage #(
            .STEP (k)
        ) u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (stg_valid[k]),
            .in_ready   (stg_ready[k]),
            .in_lane_a  (lane_a[k]),
            .in_lane_b  (lane_b[k]),
            .out_valid  (stg_valid[k+1]),
            .out_ready  (stg_ready[k+1]),
            .out_lane_a (lane_a[k+1]),
            .out_lane_b (lane_b[k+1])
        );
    end

    // offset, round, clamp, output word
    tilt_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (stg_valid[STEPS]),
        .in_ready     (stg_ready[STEPS]),
        .in_lane_a    (lane_a[STEPS]),
        .in_lane_b    (lane_b[STEPS]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .tilt_about_x (tilt_about_x),
        .tilt_about_y (tilt_about_y)
    );

    assign m_tdata = {tilt_about_y, tilt_about_x};

    // a ready receiver never blocks the input side
    a_ready_chain: assert property (@(posedge aclk) m_tready |-> s_tready)
        else $error("input stalled while the output side is ready");

    // results stay within 0..360 degrees
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (tilt_about_x <= ANG_MAX) && (tilt_about_y <= ANG_MAX))
        else $error("tilt angle out of range");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

endmodule

`default_nettype wire
